// ----- src/lge_pkg.sv -----
package lge_pkg;

  // Default grid size.
  localparam int RowsDef = 16;
  localparam int ColsDef = 16;

  // Fixed field widths.
  localparam int OpW   = 2;
  localparam int IdxW  = 4;
  localparam int OutW  = 16;
  localparam int CountW = 4;

  // Neighbor counts of rule B3/S23.
  localparam logic [CountW-1:0] BirthCount   = 4'd3;
  localparam logic [CountW-1:0] SurviveCount = 4'd2;

  typedef enum logic [OpW-1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_ACCESS = 2'd1,
    ST_GEN    = 2'd2,
    ST_DONE   = 2'd3
  } state_e;

endpackage

// ----- src/lge_row_unit.sv -----
module lge_row_unit import lge_pkg::*; #(
  parameter int COLS = ColsDef
) (
  input  logic [COLS-1:0] prev_row_i,
  input  logic [COLS-1:0] cur_row_i,
  input  logic [COLS-1:0] next_row_i,
  output logic [COLS-1:0] new_row_o
);

  // The border columns always stay dead.
  assign new_row_o[0]      = 1'b0;
  assign new_row_o[COLS-1] = 1'b0;

  // Each interior column counts its eight neighbors and applies the rule.
  for (genvar c = 1; c < COLS - 1; c++) begin : g_col
    logic [CountW-1:0] count;

    assign count = CountW'(prev_row_i[c-1]) + CountW'(prev_row_i[c])
                 + CountW'(prev_row_i[c+1]) + CountW'(cur_row_i[c-1])
                 + CountW'(cur_row_i[c+1])  + CountW'(next_row_i[c-1])
                 + CountW'(next_row_i[c])   + CountW'(next_row_i[c+1]);

    assign new_row_o[c] = (count == BirthCount)
                        || (cur_row_i[c] && (count == SurviveCount));
  end

endmodule

// ----- src/life_generation_engine_top.sv -----
// Channel | Direction | Handshake               | Word
// in      | input     | in_valid_i / in_ready_o   | opcode_i, row_index_i, col_index_i, cell_value_i
// out     | output    | out_valid_o / out_ready_i | row_cells_o
//
// A cell write or row read passes through the access state and then the done state, where its result
// is loaded into the output register. A generation passes through the generate and done states;
// one grid row per cycle streams through a three-row window into the row unit.
// Reset clears the per-row valid bits, so the whole grid reads as dead at once.
// Input is accepted only in the idle state; a new word may be accepted while the
// previous result still waits, and the next result then stalls until that one is taken.
module life_generation_engine_top import lge_pkg::*; #(
  parameter int ROWS = RowsDef,
  parameter int COLS = ColsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [OpW-1:0]  opcode_i,
  input  logic [IdxW-1:0] row_index_i,
  input  logic [IdxW-1:0] col_index_i,
  input  logic            cell_value_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [OutW-1:0] row_cells_o
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(ROWS + 1);

  state_e state_q, state_d;

  // Latched input word.
  opcode_e         op_q, op_d;
  logic [IdxW-1:0] row_q, row_d;
  logic [IdxW-1:0] col_q, col_d;
  logic            val_q, val_d;

  // Grid memory and per-row valid bits.
  logic [COLS-1:0] grid_mem [ROWS];
  logic [ROWS-1:0] row_vld_q;
  logic            rd_en;
  logic [RW-1:0]   rd_addr;
  logic [COLS-1:0] rd_data_q;
  logic            rd_vld_q;
  logic            wr_en;
  logic [RW-1:0]   wr_addr;
  logic [COLS-1:0] wr_data;
  logic [COLS-1:0] acc_row;

  // Generation sequencer.
  logic [CW-1:0]   gen_ctr_q, gen_ctr_d;
  logic            arr_vld_q;
  logic [RW-1:0]   arr_row_q;
  logic [COLS-1:0] win_prev_q, win_prev_d;
  logic [COLS-1:0] win_cur_q, win_cur_d;
  logic [COLS-1:0] new_row;

  // Result and output register.
  logic [OutW-1:0] res_q, res_d;
  logic [OutW-1:0] row_view;
  logic            out_load;
  logic            out_valid_q;
  logic [OutW-1:0] row_cells_q;

  logic            row_ok;
  logic            cell_ok;
  logic [COLS-1:0] bit_mask;

  assign acc_row = rd_vld_q ? rd_data_q : '0;

  // The low sixteen columns of the row just read.
  for (genvar j = 0; j < OutW; j++) begin : g_view
    if (j < COLS) begin : g_col
      assign row_view[j] = acc_row[j];
    end else begin : g_pad
      assign row_view[j] = 1'b0;
    end
  end

  // Range checks on the latched indexes.
  assign row_ok   = 32'(row_q) < ROWS;
  assign cell_ok  = (row_q != '0) && (32'(row_q) + 1 < ROWS)
                 && (col_q != '0) && (32'(col_q) + 1 < COLS);
  assign bit_mask = COLS'(1) << col_q;

  lge_row_unit #(
    .COLS(COLS)
  ) u_row_unit (
    .prev_row_i(win_prev_q),
    .cur_row_i (win_cur_q),
    .next_row_i(acc_row),
    .new_row_o (new_row)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (opcode_e'(opcode_i))
            OP_WRITE, OP_READ: state_d = ST_ACCESS;
            OP_STEP:           state_d = ST_GEN;
            default:           state_d = ST_DONE;
          endcase
        end
      end
      ST_ACCESS: state_d = ST_DONE;
      ST_GEN: begin
        if (arr_vld_q && (arr_row_q == RW'(ROWS - 1))) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control for each state.
  always_comb begin
    op_d       = op_q;
    row_d      = row_q;
    col_d      = col_q;
    val_d      = val_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    gen_ctr_d  = gen_ctr_q;
    win_prev_d = win_prev_q;
    win_cur_d  = win_cur_q;
    res_d      = res_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d  = opcode_e'(opcode_i);
          row_d = row_index_i;
          col_d = col_index_i;
          val_d = cell_value_i;
          res_d = '0;
          case (opcode_e'(opcode_i))
            OP_WRITE, OP_READ: begin
              rd_en   = 1'b1;
              rd_addr = RW'(row_index_i);
            end
            OP_STEP: begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              gen_ctr_d = CW'(1);
            end
            default: ;
          endcase
        end
      end
      ST_ACCESS: begin
        if (op_q == OP_WRITE) begin
          if (cell_ok) begin
            wr_en   = 1'b1;
            wr_addr = RW'(row_q);
            wr_data = val_q ? (acc_row | bit_mask) : (acc_row & ~bit_mask);
          end
        end else if (row_ok) begin
          res_d = row_view;
        end
      end
      ST_GEN: begin
        // Keep issuing row reads until the last row is requested.
        if (32'(gen_ctr_q) < ROWS) begin
          rd_en     = 1'b1;
          rd_addr   = gen_ctr_q[RW-1:0];
          gen_ctr_d = gen_ctr_q + CW'(1);
        end
        // A returning row completes the window for the row above it.
        if (arr_vld_q) begin
          if (arr_row_q >= RW'(2)) begin
            wr_en   = 1'b1;
            wr_addr = arr_row_q - RW'(1);
            wr_data = new_row;
          end
          win_prev_d = win_cur_q;
          win_cur_d  = acc_row;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gen_ctr_q   <= '0;
      arr_vld_q   <= 1'b0;
      arr_row_q   <= '0;
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      gen_ctr_q <= gen_ctr_d;
      arr_vld_q <= rd_en;
      arr_row_q <= rd_addr;
      if (wr_en) begin
        row_vld_q[wr_addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    row_q      <= row_d;
    col_q      <= col_d;
    val_q      <= val_d;
    win_prev_q <= win_prev_d;
    win_cur_q  <= win_cur_d;
    res_q      <= res_d;
    if (out_load) begin
      row_cells_q <= res_q;
    end
  end

  // Grid memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= grid_mem[rd_addr];
      rd_vld_q  <= row_vld_q[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_cells_o = row_cells_q;

`ifndef SYNTHESIS
  // A word taken while idle always moves the sequencer out of the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE))
    else $error("accepted word did not start an operation");

  // The top and bottom rows are never written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ((wr_addr != '0) && (wr_addr != RW'(ROWS - 1))))
    else $error("write to a border row");

  // Border columns of a written row stay dead.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (!wr_data[0] && !wr_data[COLS-1]))
    else $error("live cell written into a border column");

  // A new result is loaded only from the done state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DONE))
    else $error("result presented outside the done state");

  // Memory reads are issued only while idle or generating.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> ((state_q == ST_IDLE) || (state_q == ST_GEN)))
    else $error("unexpected grid read");
`endif

endmodule
